[rtl/core/masked_opcode_match_table_unit_macros.svh]
// assertion macros for the opcode match table
`ifndef MASKED_OPCODE_MATCH_TABLE_UNIT_MACROS_SVH
`define MASKED_OPCODE_MATCH_TABLE_UNIT_MACROS_SVH
// assert that a implies b on the next clock edge
`define MOMT_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");
// assert that a implies b in the same cycle
`define MOMT_ASSERT_SAME(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");
`endif

[rtl/core/momt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// momt_pkg
// shared types and codes of the opcode match table
// ----------------------------------------------------------------------------
package momt_pkg;
   localparam logic [1:0] OP_LOOKUP = 2'd0;
   localparam logic [1:0] OP_REG16  = 2'd1;
   localparam logic [1:0] OP_REG32  = 2'd2;
   // no operation, answers with the current count
   localparam logic [1:0] OP_NOP    = 2'd3;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_ILLEGAL    = 3'd1;
   localparam logic [2:0] ST_BAD_PREFIX = 3'd2;
   localparam logic [2:0] ST_NEVER      = 3'd3;
   localparam logic [2:0] ST_FULL       = 3'd4;

   typedef struct packed {
      logic [1:0]  operation;
      logic [31:0] instruction;
      logic [31:0] set_mask;
      logic [31:0] clear_mask;
      logic [31:0] first_exception_ones;
      logic [31:0] first_exception_zeros;
      logic [31:0] second_exception_ones;
      logic [31:0] second_exception_zeros;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic       matched;
      logic [7:0] entry_index;
      logic [8:0] registered_count;
   } rsp_type;

   // pattern as it lives in one cell
   typedef struct packed {
      logic        is_short;
      logic [31:0] ones;
      logic [31:0] zeros;
   } pat_type;

   typedef struct packed {
      logic        present;
      logic [31:0] ones;
      logic [31:0] zeros;
   } exc_type;

   function automatic logic mask_hit(logic [31:0] w, logic [31:0] o, logic [31:0] z);
      mask_hit = ((w & o) == o) && ((~w & z) == z);
   endfunction
endpackage

[rtl/core/momt_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// momt_req_if / momt_rsp_if
// valid/ready channels for requests and responses
// ----------------------------------------------------------------------------
interface momt_req_if;
   logic               valid;
   logic               ready;
   momt_pkg::req_type  payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface momt_rsp_if;
   logic               valid;
   logic               ready;
   momt_pkg::rsp_type  payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

[rtl/core/momt_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// momt_cell
// one table entry; matches the word passing by and forwards the best hit
// ----------------------------------------------------------------------------
module momt_cell #(
   parameter int EXC = 2,
   parameter int IW  = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   write,
   input  momt_pkg::pat_type      wr_pat,
   input  momt_pkg::exc_type      wr_exc [EXC],
   input  logic [IW-1:0]          my_index,
   input  logic                   step,
   input  logic [31:0]            word,
   input  logic                   want_short,
   input  logic                   hit_prev,
   input  logic [IW-1:0]          idx_prev,
   output logic                   hit_out,
   output logic [IW-1:0]          idx_out
);
   logic              valid_ff;
   momt_pkg::pat_type pat_ff;
   momt_pkg::exc_type exc_ff [EXC];
   logic              here;
   logic              hit_ff;
   logic [IW-1:0]     idx_ff;
   logic              hit_in;
   logic [IW-1:0]     idx_in;

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (write) valid_ff <= 1'b1;
      if (write) begin
         pat_ff <= wr_pat;
         exc_ff <= wr_exc;
      end
   end

   always_comb begin
      here = valid_ff && (pat_ff.is_short == want_short) &&
             momt_pkg::mask_hit(word, pat_ff.ones, pat_ff.zeros);
      for (int k = 0; k < EXC; k++)
         if (exc_ff[k].present && momt_pkg::mask_hit(word, exc_ff[k].ones, exc_ff[k].zeros))
            here = 1'b0;
      // later cells are newer, so a local hit overrides what came in
      hit_in = here | hit_prev;
      idx_in = here ? my_index : idx_prev;
   end

   always_ff @(posedge clock) begin
      if (reset) hit_ff <= 1'b0;
      else if (step) hit_ff <= hit_in;
      if (step) idx_ff <= idx_in;
   end

   assign hit_out = hit_ff;
   assign idx_out = idx_ff;
endmodule

[rtl/core/masked_opcode_match_table_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_opcode_match_table_unit
// thumb pattern table: registration and newest-first ternary lookup
// ----------------------------------------------------------------------------
// Each entry is a cell in a chain. A lookup word is held still while the
// best hit ripples one cell per cycle from the oldest entry to the newest;
// the scan state then hands over to a response state that registers the
// result. A registration writes one cell and its response is valid in the
// cycle after acceptance. One transaction is in work at a time; the
// response register frees the request side once taken.
`include "masked_opcode_match_table_unit_macros.svh"
module masked_opcode_match_table_unit #(
   parameter int TABLE_ENTRIES = 256,
   parameter int EXCEPTIONS_PER_ENTRY = 2
) (
   input  logic  clock,
   input  logic  reset,
   momt_req_if.sink   req,
   momt_rsp_if.source rsp
);
   localparam int IW = $clog2(TABLE_ENTRIES);
   localparam int CW = $clog2(TABLE_ENTRIES + 1);
   localparam int NE = (EXCEPTIONS_PER_ENTRY < 2) ? EXCEPTIONS_PER_ENTRY : 2;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_RESP = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [CW-1:0]         scan_ff, scan_in;
   logic [31:0]           word_ff;
   logic                  short_ff;
   logic                  legal_ff;
   momt_pkg::rsp_type     out_ff, out_in;
   logic                  outv_ff, outv_in;

   logic                  accept;
   logic [31:0]           cut;
   logic [4:0]            otop, ztop, wtop;
   logic                  pre_ok;
   logic [2:0]            rstat;
   logic                  do_write;
   momt_pkg::pat_type     wpat;
   momt_pkg::exc_type     wexc [EXCEPTIONS_PER_ENTRY];
   logic                  w_short, w_legal;

   logic                  hit_chain [TABLE_ENTRIES+1];
   logic [IW-1:0]         idx_chain [TABLE_ENTRIES+1];

   assign accept    = req.valid && req.ready;
   assign req.ready = (state_ff == S_IDLE) && !outv_ff;
   assign rsp.valid = outv_ff;
   assign rsp.payload = out_ff;

   // registration decode
   always_comb begin
      logic [31:0] eo [2];
      logic [31:0] ez [2];
      logic        going;
      cut  = (req.payload.operation == momt_pkg::OP_REG16) ? 32'h0000_ffff : 32'hffff_ffff;
      otop = req.payload.set_mask[31:27];
      ztop = req.payload.clear_mask[31:27];
      pre_ok = (otop == 5'h1d || otop == 5'h1e || otop == 5'h1f) && (ztop == ~otop);
      rstat = momt_pkg::ST_OK;
      if (req.payload.operation == momt_pkg::OP_REG16) begin
         if ((req.payload.set_mask[15:8] & req.payload.clear_mask[15:8]) != 8'd0)
            rstat = momt_pkg::ST_NEVER;
         else if (count_ff >= CW'(TABLE_ENTRIES)) rstat = momt_pkg::ST_FULL;
      end else begin
         if (req.payload.clear_mask[31:16] == 16'd0 || !pre_ok)
            rstat = momt_pkg::ST_BAD_PREFIX;
         else if ((req.payload.set_mask[26:19] & req.payload.clear_mask[26:19]) != 8'd0)
            rstat = momt_pkg::ST_NEVER;
         else if (count_ff >= CW'(TABLE_ENTRIES)) rstat = momt_pkg::ST_FULL;
      end
      do_write = accept && (req.payload.operation == momt_pkg::OP_REG16 ||
                 req.payload.operation == momt_pkg::OP_REG32) && rstat == momt_pkg::ST_OK;
      wpat.is_short = (req.payload.operation == momt_pkg::OP_REG16);
      wpat.ones  = req.payload.set_mask & cut;
      wpat.zeros = req.payload.clear_mask & cut;
      eo[0] = req.payload.first_exception_ones & cut;
      ez[0] = req.payload.first_exception_zeros & cut;
      eo[1] = req.payload.second_exception_ones & cut;
      ez[1] = req.payload.second_exception_zeros & cut;
      going = 1'b1;
      for (int k = 0; k < EXCEPTIONS_PER_ENTRY; k++) begin
         wexc[k].present = 1'b0;
         wexc[k].ones  = 32'd0;
         wexc[k].zeros = 32'd0;
         if (k < NE) begin
            if ((eo[k] | ez[k]) == 32'd0) going = 1'b0;
            wexc[k].present = going;
            wexc[k].ones  = eo[k];
            wexc[k].zeros = ez[k];
         end else going = 1'b0;
      end
   end

   // lookup pool selection
   always_comb begin
      wtop = req.payload.instruction[31:27];
      w_short = (req.payload.instruction[31:16] == 16'd0);
      w_legal = w_short || wtop == 5'h1d || wtop == 5'h1e || wtop == 5'h1f;
   end

   // chain of entry cells, oldest first
   assign hit_chain[0] = 1'b0;
   assign idx_chain[0] = '0;
   for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
      momt_cell #(.EXC(EXCEPTIONS_PER_ENTRY), .IW(IW)) u_cell (
         .clock      (clock),
         .reset      (reset),
         .write      (do_write && count_ff[IW-1:0] == IW'(g)),
         .wr_pat     (wpat),
         .wr_exc     (wexc),
         .my_index   (IW'(g)),
         .step       (state_ff == S_SCAN),
         .word       (word_ff),
         .want_short (short_ff),
         .hit_prev   (hit_chain[g]),
         .idx_prev   (idx_chain[g]),
         .hit_out    (hit_chain[g+1]),
         .idx_out    (idx_chain[g+1])
      );
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      scan_in  = scan_ff;
      out_in   = out_ff;
      outv_in  = outv_ff && !rsp.ready;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               out_in.status = momt_pkg::ST_OK;
               out_in.matched = 1'b0;
               out_in.entry_index = 8'd0;
               out_in.registered_count = 9'(count_ff);
               if (req.payload.operation == momt_pkg::OP_LOOKUP) begin
                  state_in = S_SCAN;
                  scan_in = '0;
               end else begin
                  if (req.payload.operation != momt_pkg::OP_NOP) out_in.status = rstat;
                  if (do_write) begin
                     count_in = count_ff + CW'(1);
                     out_in.entry_index = 8'(count_ff);
                     out_in.registered_count = 9'(count_ff + CW'(1));
                  end
                  outv_in = 1'b1;
               end
            end
         end
         S_SCAN: begin
            scan_in = scan_ff + CW'(1);
            if (scan_ff == CW'(TABLE_ENTRIES)) state_in = S_RESP;
         end
         S_RESP: begin
            state_in = S_IDLE;
            outv_in = 1'b1;
            out_in.matched = legal_ff && hit_chain[TABLE_ENTRIES];
            out_in.status = out_in.matched ? momt_pkg::ST_OK : momt_pkg::ST_ILLEGAL;
            out_in.entry_index = out_in.matched ? 8'(idx_chain[TABLE_ENTRIES]) : 8'd0;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         outv_ff  <= 1'b0;
         scan_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         outv_ff  <= outv_in;
         scan_ff  <= scan_in;
      end
      out_ff <= out_in;
      if (accept) begin
         word_ff  <= req.payload.instruction;
         short_ff <= w_short;
         legal_ff <= w_legal;
      end
   end

   `MOMT_ASSERT_SAME(a_no_accept_busy, clock, reset, state_ff != S_IDLE, !req.ready)
   `MOMT_ASSERT_NEXT(a_write_counts, clock, reset, do_write, count_ff == $past(count_ff) + CW'(1))
   `MOMT_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(TABLE_ENTRIES))
   `MOMT_ASSERT_NEXT(a_resp_valid, clock, reset, state_ff == S_RESP, rsp.valid)
endmodule
